>>> hdl/hinf_computed_torque_control_assert.svh
// Assertion macros used by the checker file.
`ifndef HINF_COMPUTED_TORQUE_CONTROL_ASSERT_SVH
`define HINF_COMPUTED_TORQUE_CONTROL_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define HCTC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property that must also hold while reset is asserted.
`define HCTC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/hctc_pkg.sv
// ----------------------------------------------------------------------------
// hctc_pkg
// Types, constants and helpers of the computed-torque controller.
// ----------------------------------------------------------------------------
package hctc_pkg;

	localparam int JOINTS    = 12;
	localparam int FRAC_BITS = 16;
	localparam int JW        = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int MAT_DEPTH = JOINTS * JOINTS;
	localparam int ACC_W     = 56;
	localparam int PROD_W    = 66;
	localparam int DIV_W     = 2 * FRAC_BITS + 1;
	localparam int DIV_CW    = $clog2(DIV_W + 1);

	localparam logic [15:0] TIME_STEP_RST = 16'd66;
	localparam logic [30:0] KP_RST        = 31'd6553600;
	localparam logic [30:0] KV_RST        = 31'd1310720;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	typedef enum logic [1:0] {
		REQ_MATRIX  = 2'd0,
		REQ_JOINT   = 2'd1,
		REQ_GAIN    = 2'd2,
		REQ_COMPUTE = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		CFG_TIME_STEP = 2'd0,
		CFG_POS_GAIN  = 2'd1,
		CFG_VEL_GAIN  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_DT   = 3'd0,
		OP_KVED = 3'd1,
		OP_KPE  = 3'd2,
		OP_KVE  = 3'd3,
		OP_KPEI = 3'd4,
		OP_M    = 3'd5,
		OP_C    = 3'd6,
		OP_G    = 3'd7
	} op_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic signed [31:0] desired_pos;
		logic signed [31:0] desired_vel;
		logic signed [31:0] desired_acc;
		logic signed [31:0] gravity;
	} req_t;

	typedef struct packed {
		logic [3:0]         joint_index;
		logic signed [31:0] torque;
		logic               last;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [31:0] r;
		if (x > ACC_W'(Q_MAX))
			r = Q_MAX;
		else if (x < ACC_W'(Q_MIN))
			r = Q_MIN;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

>>> hdl/hctc_ram.sv
// ----------------------------------------------------------------------------
// hctc_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module hctc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> hdl/hctc_div.sv
// ----------------------------------------------------------------------------
// hctc_div
// Restoring divider: 2^(2*FRAC_BITS) / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hctc_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      divisor,
	output logic             done,
	output logic [hctc_pkg::DIV_W-1:0] quotient
);
	import hctc_pkg::*;

	logic              active_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [31:0]       dvs_q;
	logic [31:0]       rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [32:0]       trial;
	logic              fits;

	// the dividend is a single one at its top bit
	assign trial = {rem_q, (cnt_q == DIV_CW'(DIV_W - 1))};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= DIV_CW'(DIV_W - 1);
			end else if (active_q) begin
				if (cnt_q == '0) begin
					active_q <= 1'b0;
					done     <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (active_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule

>>> hdl/hinf_computed_torque_control.sv
// Loads of matrix elements and joint data leave the sequencer idle; the block is ready again next cycle.
// A gain load runs the divider, which forms the reciprocal of gamma at Q16.16, and holds the block busy.
// A compute request runs every product through the single shared multiplier (S_MUL, then S_ACC),
// with one RAM read per column, and can be held by output stalls.
// Results leave one per joint from an output register; no new request is taken meanwhile.
// Reset clears the sequencer and the integral errors and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// hinf_computed_torque_control
// H-infinity computed-torque controller with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module hinf_computed_torque_control (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  hctc_pkg::req_t    req_data,
	output logic              res_valid,
	input  logic              res_ready,
	output hctc_pkg::res_t    res_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import hctc_pkg::*;

	localparam int AW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DIV   = 8'b0000_0010,
		S_PREP  = 8'b0000_0100,
		S_MUL   = 8'b0000_1000,
		S_ACC   = 8'b0001_0000,
		S_ROW   = 8'b0010_0000,
		S_RD    = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	op_t    op_q;

	logic [15:0] dt_q;
	logic [30:0] kp_q;
	logic [30:0] kv_q;

	logic signed [31:0] jp_q [JOINTS];
	logic signed [31:0] jv_q [JOINTS];
	logic signed [31:0] tp_q [JOINTS];
	logic signed [31:0] tv_q [JOINTS];
	logic signed [31:0] ta_q [JOINTS];
	logic signed [31:0] grav_q [JOINTS];
	logic signed [31:0] gain_q [JOINTS];
	logic signed [31:0] ie_q [JOINTS];
	logic signed [31:0] ddref_q [JOINTS];
	logic signed [31:0] dref_q [JOINTS];
	logic signed [31:0] slide_q [JOINTS];

	logic [JW-1:0]      jidx_q;
	logic [JW-1:0]      row_q;
	logic [JW-1:0]      col_q;
	logic [AW-1:0]      maddr_q;
	logic signed [31:0] e_q;
	logic signed [31:0] ed_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PROD_W-1:0] prod_q;
	res_t               res_q;

	logic [JW-1:0]      grow_q;
	logic signed [31:0] gk_q;
	logic               gneg_q;

	logic               accept;
	logic               in_range;
	logic               mat_we;
	logic [AW-1:0]      mat_waddr;
	logic               mat_re;
	logic [63:0]        mat_rdata;
	logic [JW-1:0]      rix;

	logic               div_start;
	logic               div_done;
	logic [DIV_W-1:0]   div_q;
	logic [31:0]        gmag;
	logic signed [ACC_W-1:0] qx;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0] sh;
	logic signed [ACC_W-1:0] sum;
	logic signed [32:0] dpos;
	logic signed [32:0] dvel;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = req_valid && req_ready;
	assign rix       = JW'(req_data.row);
	assign in_range  = (int'(req_data.row) < JOINTS);

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= TIME_STEP_RST;
			kp_q <= KP_RST;
			kv_q <= KV_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_TIME_STEP: dt_q <= cfg_data[15:0];
				CFG_POS_GAIN:  kp_q <= cfg_data[30:0];
				CFG_VEL_GAIN:  kv_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// ---------------- matrix store ----------------
	assign mat_we    = accept && (req_data.req_type == REQ_MATRIX) && in_range &&
		(int'(req_data.col) < JOINTS);
	assign mat_waddr = AW'(int'(req_data.row) * JOINTS + int'(req_data.col));
	assign mat_re    = (state_q == S_ROW) || ((state_q == S_ACC) && (op_q == OP_C) &&
		(col_q != JW'(JOINTS - 1)));

	hctc_ram #(
		.WIDTH (64),
		.DEPTH (MAT_DEPTH)
	) u_mat (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata ({req_data.value_a, req_data.value_b}),
		.re    (mat_re),
		.raddr (maddr_q),
		.rdata (mat_rdata)
	);

	// ---------------- gain reciprocal ----------------
	assign gmag      = req_data.value_b[31] ? 32'(-req_data.value_b) : 32'(req_data.value_b);
	assign div_start = accept && (req_data.req_type == REQ_GAIN) && in_range &&
		(req_data.value_b != '0);
	assign qx        = $signed({{(ACC_W - DIV_W){1'b0}}, div_q});

	hctc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (gmag),
		.done     (div_done),
		.quotient (div_q)
	);

	// ---------------- shared multiplier ----------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_DT: begin
				mul_a = 33'(e_q);
				mul_b = $signed({17'b0, dt_q});
			end
			OP_KVED: begin
				mul_a = $signed({2'b0, kv_q});
				mul_b = 33'(ed_q);
			end
			OP_KPE: begin
				mul_a = $signed({2'b0, kp_q});
				mul_b = 33'(e_q);
			end
			OP_KVE: begin
				mul_a = $signed({2'b0, kv_q});
				mul_b = 33'(e_q);
			end
			OP_KPEI: begin
				mul_a = $signed({2'b0, kp_q});
				mul_b = 33'(ie_q[jidx_q]);
			end
			OP_M: begin
				mul_a = 33'($signed(mat_rdata[63:32]));
				mul_b = 33'(ddref_q[col_q]);
			end
			OP_C: begin
				mul_a = 33'($signed(mat_rdata[31:0]));
				mul_b = 33'(dref_q[col_q]);
			end
			OP_G: begin
				mul_a = 33'(gain_q[row_q]);
				mul_b = 33'(slide_q[row_q]);
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;
	// arithmetic shift gives the floor of the scaled product
	assign sh   = ACC_W'(prod_q >>> FRAC_BITS);
	assign sum  = acc_q + sh;
	assign dpos = 33'(tp_q[jidx_q]) - 33'(jp_q[jidx_q]);
	assign dvel = 33'(tv_q[jidx_q]) - 33'(jv_q[jidx_q]);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_DT;
			jidx_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
			maddr_q <= '0;
			for (int k = 0; k < JOINTS; k++)
				ie_q[k] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (req_data.req_type == REQ_COMPUTE)) begin
						jidx_q  <= '0;
						maddr_q <= '0;
						state_q <= S_PREP;
					end else if (div_start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_IDLE;
				end
				S_PREP: begin
					op_q    <= OP_DT;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= S_MUL;
					case (op_q)
						OP_DT: begin
							ie_q[jidx_q] <= sat32(ACC_W'(ie_q[jidx_q]) + sh);
							op_q <= OP_KVED;
						end
						OP_KVED: op_q <= OP_KPE;
						OP_KPE:  op_q <= OP_KVE;
						OP_KVE:  op_q <= OP_KPEI;
						OP_KPEI: begin
							if (jidx_q == JW'(JOINTS - 1)) begin
								row_q   <= '0;
								state_q <= S_ROW;
							end else begin
								jidx_q  <= jidx_q + 1'b1;
								state_q <= S_PREP;
							end
						end
						OP_M: op_q <= OP_C;
						OP_C: begin
							if (col_q == JW'(JOINTS - 1)) begin
								op_q <= OP_G;
							end else begin
								col_q   <= col_q + 1'b1;
								maddr_q <= maddr_q + 1'b1;
								op_q    <= OP_M;
								state_q <= S_RD;
							end
						end
						OP_G: state_q <= S_OUT;
						default: state_q <= S_IDLE;
					endcase
				end
				S_ROW: begin
					col_q   <= '0;
					maddr_q <= maddr_q + 1'b1;
					op_q    <= OP_M;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_MUL;
				end
				S_OUT: begin
					if (res_ready) begin
						if (row_q == JW'(JOINTS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_ROW;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (accept && (req_data.req_type == REQ_JOINT) && in_range) begin
			jp_q[rix]   <= req_data.position;
			jv_q[rix]   <= req_data.velocity;
			tp_q[rix]   <= req_data.desired_pos;
			tv_q[rix]   <= req_data.desired_vel;
			ta_q[rix]   <= req_data.desired_acc;
			grav_q[rix] <= req_data.gravity;
		end
		if (accept && (req_data.req_type == REQ_GAIN) && in_range) begin
			grow_q <= rix;
			gk_q   <= req_data.value_a;
			gneg_q <= req_data.value_b[31];
			// zero gamma saturates the sum
			if (req_data.value_b == '0)
				gain_q[rix] <= Q_MAX;
		end
		if ((state_q == S_DIV) && div_done)
			gain_q[grow_q] <= sat32(ACC_W'(gk_q) + (gneg_q ? -qx : qx));

		if (state_q == S_PREP) begin
			e_q  <= sat32(ACC_W'(dpos));
			ed_q <= sat32(ACC_W'(dvel));
		end
		if (state_q == S_MUL)
			prod_q <= prod;
		if (state_q == S_ROW)
			acc_q <= ACC_W'(grav_q[row_q]);
		if (state_q == S_ACC) begin
			case (op_q)
				OP_KVED: acc_q <= ACC_W'(ta_q[jidx_q]) + sh;
				OP_KPE:  ddref_q[jidx_q] <= sat32(sum);
				OP_KVE:  acc_q <= sh;
				OP_KPEI: begin
					dref_q[jidx_q]  <= sat32(ACC_W'(tv_q[jidx_q]) + sum);
					slide_q[jidx_q] <= sat32(ACC_W'(ed_q) + sum);
				end
				OP_M:    acc_q <= sum;
				OP_C:    acc_q <= sum;
				OP_G: begin
					res_q.joint_index <= 4'(row_q);
					res_q.torque      <= sat32(sum);
					res_q.last        <= (row_q == JW'(JOINTS - 1));
				end
				default: ;
			endcase
		end
	end

	assign res_valid = (state_q == S_OUT);
	assign res_data  = res_q;

endmodule

>>> hdl/hctc_checker.sv
// ----------------------------------------------------------------------------
// hctc_port_checks
// Port-level checks of the computed-torque controller.
// ----------------------------------------------------------------------------
`include "hinf_computed_torque_control_assert.svh"

module hctc_port_checks (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input hctc_pkg::req_t req_data,
	input logic           res_valid,
	input logic           res_ready,
	input hctc_pkg::res_t res_data,
	input logic           cfg_valid,
	input logic           cfg_ready,
	input logic [1:0]     cfg_index,
	input logic [31:0]    cfg_data
);
	import hctc_pkg::*;

	`HCTC_ASSERT(a_busy_while_out, res_valid |-> !req_ready, "request taken while a torque is pending")
	`HCTC_ASSERT(a_compute_busy, (req_valid && req_ready && (req_data.req_type == REQ_COMPUTE)) |=> !req_ready, "compute request did not occupy the block")
	`HCTC_ASSERT(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(res_data)), "stalled torque changed")
	`HCTC_ASSERT(a_last_ends, (res_valid && res_ready && res_data.last) |=> !res_valid, "torque after the last joint")
	`HCTC_ASSERT_ALWAYS(a_no_res_in_reset, !arst_n |-> !res_valid, "torque shown during reset")

endmodule

bind hinf_computed_torque_control hctc_port_checks u_hctc_port_checks (.*);
